FILE: hdl/balance_drive_speed_dir_mixer_unit_defines.svh
// Assertion macros shared by the motor mixer RTL.
`ifndef BALANCE_DRIVE_SPEED_DIR_MIXER_UNIT_DEFINES_SVH
`define BALANCE_DRIVE_SPEED_DIR_MIXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BDSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BDSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bdsm_pkg.sv
// Package: widths, constants, register indexes and sequencer states of the motor mixer.
package bdsm_pkg;

    // Field widths
    localparam int WHEEL_W    = 13;
    localparam int PHASE_W    = 4;
    localparam int DRIVE_W    = 16;
    localparam int COIL_W     = 16;
    localparam int TERR_W     = 12;
    localparam int TARGET_W   = 13;
    localparam int GAIN_W     = 8;
    localparam int QGAIN_W    = 16;
    localparam int DZ_W       = 12;
    localparam int LIM_W      = 14;
    localparam int THR_W      = 17;
    localparam int DUTY_W     = 15;
    localparam int SPEED_W    = 14;
    localparam int STEER_W    = 17;

    // Internal widths
    localparam int MEAN_W     = 14;
    localparam int ERR_W      = 15;
    localparam int INTEG_W    = 13;
    localparam int PI_W       = 24;
    localparam int ACC_W      = 35;
    localparam int MAG_W      = 31;
    localparam int PMAG_W     = 26;
    localparam int MIX_W      = 19;

    // Shared multiplier operand widths
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 20;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // Speed loop limits
    localparam logic signed [PI_W-1:0]    INTEG_HI  = 24'sd3000;
    localparam logic signed [PI_W-1:0]    INTEG_LO  = -24'sd2000;
    localparam logic signed [SPEED_W-1:0] SPEED_LIM = 14'sd4500;

    // Ramp: phase limit, divisor and the reciprocal used for divide by ten
    localparam logic [PHASE_W-1:0]        PHASE_MAX = 4'd9;
    localparam logic [PHASE_W-1:0]        PHASE_CNT = 4'd10;
    localparam logic signed [MUL_B_W-1:0] RAMP_DIV  = 20'sd10;
    localparam logic signed [MUL_B_W-1:0] RECIP10   = 20'sd52429;
    localparam logic [MAG_W-1:0]          RAMP_BIG  = 31'd45010;

    // Steering: reciprocal for divide by five, suppression saturation point
    localparam logic signed [MUL_B_W-1:0] RECIP5    = 20'sd419431;
    localparam logic [MAG_W-1:0]          SUPP_BIG  = 31'd1310720;
    localparam logic signed [TERR_W-1:0]  TILT_WIN  = 12'sd160;
    localparam logic [PMAG_W-1:0]         STEER_POS = 26'd65535;
    localparam logic [PMAG_W-1:0]         STEER_NEG = 26'd65536;
    localparam logic signed [STEER_W-1:0] STEER_HI  = 17'sd65535;
    localparam logic signed [STEER_W-1:0] STEER_LO  = -17'sd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_TARGET   = 3'd0,
        REG_SPEED_KP       = 3'd1,
        REG_SPEED_KI       = 3'd2,
        REG_STEER_KP       = 3'd3,
        REG_STEER_KD       = 3'd4,
        REG_DEAD_ZONE      = 3'd5,
        REG_DUTY_LIMIT     = 3'd6,
        REG_RING_THRESHOLD = 3'd7
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_MKI,
        ST_INT,
        ST_OUT,
        ST_DIFF,
        ST_RMUL1,
        ST_RMUL2,
        ST_RSUM,
        ST_RABS,
        ST_RDIV,
        ST_RCLMP,
        ST_SMUL1,
        ST_SMUL2,
        ST_SSUM,
        ST_SABS,
        ST_SDIV,
        ST_SSAT,
        ST_MIX,
        ST_DZ
    } t_state;

endpackage

FILE: hdl/bdsm_mul.sv
// Shared signed multiplier with a registered product.
module bdsm_mul (
    input  logic                                  i_clk,
    input  logic signed [bdsm_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [bdsm_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [bdsm_pkg::MUL_P_W-1:0]   o_p
);
    import bdsm_pkg::*;

    // Register the full-width product
    always_ff @(posedge i_clk) begin
        o_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

endmodule

FILE: hdl/balance_drive_speed_dir_mixer_unit.sv
// Top level of the motor mixer: speed PI, ramp, steering PD and duty mix.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | one control tick (112 bits)
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | duties and drives (64 bits)
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | register index and write data
//
// A tick runs from transfer to result as a fixed sequence of steps, which skips the speed
// PI steps when speed_update is clear, one step of the shared multiplier and adder per cycle.
// The next tick is taken once the sequence returns to idle; a result waiting in the
// output register holds the sequence only in its last step.
// Reset is synchronous: it clears the sequencer, loop state and output valid, and
// loads the register defaults. The configuration port is always ready.
`include "balance_drive_speed_dir_mixer_unit_defines.svh"

module balance_drive_speed_dir_mixer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // wheel_left[12:0], wheel_right[25:13], speed_update[26], ramp_phase[30:27],
    // tilt_drive[46:31], steer_bias[62:47], coil_left[78:63], coil_right[94:79],
    // tilt_error[106:95], steer_enable[107], zero fill[111:108]
    input  logic [bdsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // duty_left[14:0], duty_right[29:15], speed_drive[43:30], steer_drive[60:44],
    // zero fill[63:61]
    output logic [bdsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bdsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bdsm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bdsm_pkg::*;

    // Configuration registers
    logic signed [TARGET_W-1:0] r_speed_target;
    logic [GAIN_W-1:0]          r_speed_kp;
    logic [GAIN_W-1:0]          r_speed_ki;
    logic [QGAIN_W-1:0]         r_steer_kp;
    logic [QGAIN_W-1:0]         r_steer_kd;
    logic [DZ_W-1:0]            r_dead_zone;
    logic [LIM_W-1:0]           r_duty_limit;
    logic [THR_W-1:0]           r_ring_threshold;

    // Captured tick
    logic signed [WHEEL_W-1:0]  r_wl;
    logic signed [WHEEL_W-1:0]  r_wr;
    logic [PHASE_W-1:0]         r_phase;
    logic signed [DRIVE_W-1:0]  r_tilt;
    logic signed [DRIVE_W-1:0]  r_bias;
    logic [COIL_W-1:0]          r_cl;
    logic [COIL_W-1:0]          r_cr;
    logic signed [TERR_W-1:0]   r_terr;
    logic                       r_en;

    // Loop state
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [PI_W-1:0]     r_now;
    logic signed [PI_W-1:0]     r_before;
    logic signed [DRIVE_W-1:0]  r_bias_before;
    logic signed [STEER_W-1:0]  r_hold;

    // Working registers
    t_state                     r_state;
    t_state                     n_state;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [ACC_W-1:0]    r_acc;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic                       r_big;
    logic                       r_supp;
    logic signed [SPEED_W-1:0]  r_speed_drive;
    logic signed [MIX_W-1:0]    r_left;
    logic signed [MIX_W-1:0]    r_right;

    // Output register
    logic                       r_out_valid;
    logic signed [DUTY_W-1:0]   r_duty_left;
    logic signed [DUTY_W-1:0]   r_duty_right;
    logic signed [SPEED_W-1:0]  r_out_speed;
    logic signed [STEER_W-1:0]  r_out_steer;

    // Combinational helpers
    logic                       w_in_xfer;
    logic                       w_out_free;
    logic signed [MEAN_W:0]     w_wsum;
    logic signed [MEAN_W:0]     w_wsum_adj;
    logic signed [MEAN_W-1:0]   w_mean;
    logic signed [PI_W-1:0]     w_isum;
    logic signed [ACC_W-1:0]    w_acc_neg;
    logic signed [ACC_W-1:0]    w_acc_abs;
    logic [PHASE_W-1:0]         w_factor;
    logic signed [STEER_W-1:0]  w_bias_diff;
    logic [SPEED_W-2:0]         w_rq;
    logic [SPEED_W-2:0]         w_rmag;
    logic [DRIVE_W-1:0]         w_sq;
    logic [PMAG_W-1:0]          w_pmag;
    logic signed [STEER_W-1:0]  w_pd;
    logic [THR_W-1:0]           w_coil_sum;
    logic signed [MIX_W-1:0]    w_tsd;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [MUL_P_W-1:0]  w_prod;

    // Dead zone by sign, then symmetric clamp to the duty limit
    function automatic logic signed [DUTY_W-1:0] dz_apply(
        input logic signed [MIX_W-1:0] v,
        input logic [DZ_W-1:0]         dz,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [MIX_W:0] vx;
        logic signed [MIX_W:0] vd;
        logic signed [MIX_W:0] lp;
        logic signed [MIX_W:0] w;
        vx = (MIX_W + 1)'(v);
        vd = $signed({{(MIX_W + 1 - DZ_W){1'b0}}, dz});
        lp = $signed({{(MIX_W + 1 - LIM_W){1'b0}}, lim});
        if (vx > 0) begin
            w = vx + vd;
        end else if (vx < 0) begin
            w = vx - vd;
        end else begin
            w = '0;
        end
        if (w > lp) begin
            w = lp;
        end else if (w < -lp) begin
            w = -lp;
        end
        return DUTY_W'(w);
    endfunction

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Mean wheel speed, truncated toward zero
    assign w_wsum     = (MEAN_W + 1)'(r_wl) + (MEAN_W + 1)'(r_wr);
    assign w_wsum_adj = w_wsum + $signed({{MEAN_W{1'b0}}, w_wsum[MEAN_W]});
    assign w_mean     = w_wsum_adj[MEAN_W:1];

    // Integral sum before the clamp
    assign w_isum = PI_W'(r_integ) + PI_W'(w_prod);

    // Magnitude of the accumulator
    assign w_acc_neg = -r_acc;
    assign w_acc_abs = r_acc[ACC_W-1] ? w_acc_neg : r_acc;

    // Ramp factor, phase held at its last step
    assign w_factor    = (r_phase > PHASE_MAX) ? PHASE_CNT : (r_phase + 4'd1);
    assign w_bias_diff = STEER_W'(r_bias) - STEER_W'(r_bias_before);

    // Ramp quotient and clamp magnitude
    assign w_rq   = w_prod[31:19];
    assign w_rmag = r_big ? SPEED_LIM[SPEED_W-2:0] : w_rq;

    // Steering magnitude after optional divide by twenty, then saturate
    assign w_sq   = w_prod[36:21];
    assign w_pmag = !r_supp ? r_mag[PMAG_W-1:0]
                  : (r_big ? STEER_NEG : {{(PMAG_W - DRIVE_W){1'b0}}, w_sq});

    always_comb begin
        if (r_neg) begin
            w_pd = (w_pmag >= STEER_NEG) ? STEER_LO : -$signed({1'b0, w_pmag[STEER_W-2:0]});
        end else begin
            w_pd = (w_pmag >= STEER_POS) ? STEER_HI : $signed({1'b0, w_pmag[STEER_W-2:0]});
        end
    end

    assign w_coil_sum = {1'b0, r_cl} + {1'b0, r_cr};
    assign w_tsd      = MIX_W'(r_tilt) - MIX_W'(r_speed_drive);

    // Select multiplier operands for each step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MKI: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({12'b0, r_speed_ki});
            end
            ST_INT: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({12'b0, r_speed_kp});
            end
            ST_RMUL1: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = $signed({16'b0, w_factor});
            end
            ST_RMUL2: begin
                w_mul_a = MUL_A_W'(r_before);
                w_mul_b = RAMP_DIV;
            end
            ST_RDIV: begin
                w_mul_a = $signed({10'b0, r_mag[15:0]});
                w_mul_b = RECIP10;
            end
            ST_SMUL1: begin
                w_mul_a = MUL_A_W'(r_bias);
                w_mul_b = $signed({4'b0, r_steer_kp});
            end
            ST_SMUL2: begin
                w_mul_a = MUL_A_W'(w_bias_diff);
                w_mul_b = $signed({4'b0, r_steer_kd});
            end
            ST_SDIV: begin
                w_mul_a = $signed({7'b0, r_mag[20:2]});
                w_mul_b = RECIP5;
            end
            default: ;
        endcase
    end

    bdsm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next step and input ready
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = s_axis_tdata[26] ? ST_ERR : ST_DIFF;
                end
            end
            ST_ERR:   n_state = ST_MKI;
            ST_MKI:   n_state = ST_INT;
            ST_INT:   n_state = ST_OUT;
            ST_OUT:   n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_RMUL1;
            ST_RMUL1: n_state = ST_RMUL2;
            ST_RMUL2: n_state = ST_RSUM;
            ST_RSUM:  n_state = ST_RABS;
            ST_RABS:  n_state = ST_RDIV;
            ST_RDIV:  n_state = ST_RCLMP;
            ST_RCLMP: n_state = ST_SMUL1;
            ST_SMUL1: n_state = ST_SMUL2;
            ST_SMUL2: n_state = ST_SSUM;
            ST_SSUM:  n_state = ST_SABS;
            ST_SABS:  n_state = ST_SDIV;
            ST_SDIV:  n_state = ST_SSAT;
            ST_SSAT:  n_state = ST_MIX;
            ST_MIX:   n_state = ST_DZ;
            ST_DZ: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_target   <= 13'sd600;
            r_speed_kp       <= 8'd30;
            r_speed_ki       <= 8'd3;
            r_steer_kp       <= 16'd256;
            r_steer_kd       <= 16'd5120;
            r_dead_zone      <= 12'd1000;
            r_duty_limit     <= 14'd6000;
            r_ring_threshold <= 17'd5000;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SPEED_TARGET:   r_speed_target   <= $signed(i_cfg_data[TARGET_W-1:0]);
                REG_SPEED_KP:       r_speed_kp       <= i_cfg_data[GAIN_W-1:0];
                REG_SPEED_KI:       r_speed_ki       <= i_cfg_data[GAIN_W-1:0];
                REG_STEER_KP:       r_steer_kp       <= i_cfg_data[QGAIN_W-1:0];
                REG_STEER_KD:       r_steer_kd       <= i_cfg_data[QGAIN_W-1:0];
                REG_DEAD_ZONE:      r_dead_zone      <= i_cfg_data[DZ_W-1:0];
                REG_DUTY_LIMIT:     r_duty_limit     <= i_cfg_data[LIM_W-1:0];
                REG_RING_THRESHOLD: r_ring_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the tick on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_wl    <= $signed(s_axis_tdata[12:0]);
            r_wr    <= $signed(s_axis_tdata[25:13]);
            r_phase <= s_axis_tdata[30:27];
            r_tilt  <= $signed(s_axis_tdata[46:31]);
            r_bias  <= $signed(s_axis_tdata[62:47]);
            r_cl    <= s_axis_tdata[78:63];
            r_cr    <= s_axis_tdata[94:79];
            r_terr  <= $signed(s_axis_tdata[106:95]);
            r_en    <= s_axis_tdata[107];
        end
    end

    // Loop state: PI memory, held steering, last bias and speed drive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ       <= '0;
            r_now         <= '0;
            r_before      <= '0;
            r_bias_before <= '0;
            r_hold        <= '0;
            r_speed_drive <= '0;
        end else begin
            case (r_state)
                ST_INT: begin
                    if (w_isum > INTEG_HI) begin
                        r_integ <= INTEG_W'(INTEG_HI);
                    end else if (w_isum < INTEG_LO) begin
                        r_integ <= INTEG_W'(INTEG_LO);
                    end else begin
                        r_integ <= INTEG_W'(w_isum);
                    end
                end
                ST_OUT: begin
                    r_before <= r_now;
                    r_now    <= PI_W'(w_prod) + PI_W'(r_integ);
                end
                ST_RCLMP: begin
                    r_speed_drive <= r_neg ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});
                end
                ST_SSUM: begin
                    r_bias_before <= r_bias;
                end
                ST_SSAT: begin
                    if (r_en) begin
                        r_hold <= w_pd;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working datapath: error, accumulator, magnitude and flags
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ERR: begin
                r_err <= ERR_W'(r_speed_target) - ERR_W'(w_mean);
            end
            ST_DIFF: begin
                r_acc <= ACC_W'(r_now) - ACC_W'(r_before);
            end
            ST_RMUL2, ST_SMUL2: begin
                r_acc <= ACC_W'(w_prod);
            end
            ST_RSUM, ST_SSUM: begin
                r_acc <= r_acc + ACC_W'(w_prod);
            end
            ST_RABS: begin
                r_neg <= r_acc[ACC_W-1];
                r_mag <= MAG_W'(w_acc_abs);
            end
            ST_RDIV: begin
                r_big <= (r_mag >= RAMP_BIG);
            end
            ST_SABS: begin
                r_neg  <= r_acc[ACC_W-1];
                r_mag  <= {{(MAG_W - (ACC_W - 9)){1'b0}}, w_acc_abs[ACC_W-2:8]};
                r_supp <= (w_coil_sum > r_ring_threshold) && (r_terr < TILT_WIN)
                          && (r_terr > -TILT_WIN);
            end
            ST_SDIV: begin
                r_big <= (r_mag >= SUPP_BIG);
            end
            ST_MIX: begin
                r_left  <= w_tsd + MIX_W'(r_hold);
                r_right <= w_tsd - MIX_W'(r_hold);
            end
            default: ;
        endcase
    end

    // Output register: load on the last step, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DZ && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DZ && w_out_free) begin
            r_duty_left  <= dz_apply(r_left, r_dead_zone, r_duty_limit);
            r_duty_right <= dz_apply(r_right, r_dead_zone, r_duty_limit);
            r_out_speed  <= r_speed_drive;
            r_out_steer  <= r_hold;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out_steer, r_out_speed, r_duty_right, r_duty_left};

    // Checks on loop state and sequencing
    `BDSM_ASSERT_IMP(a_integ_range, i_clk, i_rst_n, 1'b1,
        (r_integ >= INTEG_LO) && (r_integ <= INTEG_HI), "speed integral out of range")
    `BDSM_ASSERT_IMP(a_speed_range, i_clk, i_rst_n, 1'b1,
        (r_speed_drive >= -SPEED_LIM) && (r_speed_drive <= SPEED_LIM), "speed drive out of range")
    `BDSM_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer,
        r_state != ST_IDLE, "sequencer idle after input transfer")
    `BDSM_ASSERT_IMP(a_drop_on_xfer, i_clk, i_rst_n, $fell(r_out_valid) && $past(i_rst_n),
        $past(m_axis_tready), "result dropped without transfer")

endmodule
